// ----- sv/ffla_pkg.sv -----
package ffla_pkg;

  localparam int NUM_SLOTS    = 64;
  localparam int NUM_USERS    = 256;
  localparam int SLOT_BITS    = 6;
  localparam int LINK_BITS    = 7;
  localparam int USER_BITS    = 8;
  localparam int HEADER_BYTES = 64;

  localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(NUM_SLOTS);

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd5;

  localparam logic REG_REGION_START = 1'b0;
  localparam logic REG_REGION_END   = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  user_id;
    logic [23:0] request_size;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] data_offset;
    logic [6:0]  evicted_count;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_ALOOP, S_WRD, S_WCHK, S_EVICT, S_EVWAIT, S_CSCAN,
    S_FIND, S_PRD, S_PW1, S_PW2, S_RELRD, S_RELWR, S_FLOOP, S_TRD, S_TUL,
    S_TMR, S_TNN, S_DONE
  } state_t;

endpackage

// ----- sv/ffla_ram.sv -----
module ffla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/first_fit_lru_segment_allocator.sv -----
// Segment allocator over a byte region with least-recently-used eviction. Raise start with a
// command while busy is low; busy then stays high until the result, which appears on result
// for exactly one cycle with done high and cannot be held off. One item at a time, all work
// done by a small sequencer over registered-read slot memories. An allocate that is refused at
// once goes straight to its result; otherwise each fit pass walks the address list, a full
// table or a pass with no fit evicts the least-recently-used segment, and a commit scan then
// releases each evicted segment before a scan for a free slot. A worst-case allocate that
// evicts everything walks the address list once per eviction.
module first_fit_lru_segment_allocator
  import ffla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output res_t        result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [24:0] cfg_data
);

  state_t state, state_next;

  logic [1:0]           act;
  logic [USER_BITS-1:0] usr;
  logic [24:0]          rsize;
  logic [SLOT_BITS-1:0] s;
  logic [LINK_BITS-1:0] succ, cur, ev_ptr, p_link;
  logic [LINK_BITS-1:0] addr_first, addr_last, newest, oldest;
  logic [6:0]           evc, seg_count, ci;
  logic [25:0]          pnew;
  logic [NUM_SLOTS-1:0] gone, in_use;
  logic [NUM_USERS-1:0] user_has;
  logic [23:0]          region_start;
  logic [24:0]          region_end;

  // zero request size, kept from the accepted item
  logic cmd_zero;

  logic [23:0]          rd_start;
  logic [24:0]          rd_bytes;
  logic [USER_BITS-1:0] rd_owner;
  logic [LINK_BITS-1:0] rd_next, rd_prev, rd_newer, rd_older;
  logic [SLOT_BITS-1:0] rd_uslot;

  logic [SLOT_BITS-1:0] raddr;
  logic                 start_we, bytes_we, owner_we, next_we, prev_we, newer_we, older_we;
  logic                 uslot_we;
  logic [SLOT_BITS-1:0] next_wa, prev_wa, newer_wa, older_wa;
  logic [LINK_BITS-1:0] next_wd, prev_wd, newer_wd, older_wd;

  logic [24:0]          cmp_lhs;
  logic signed [27:0]   diff;
  logic                 fits;
  logic [6:0]           live;
  logic [LINK_BITS-1:0] p_comb;
  logic [25:0]          seg_end;

  // shared subtract and compare
  assign cmp_lhs = (state == S_WCHK) ? {1'b0, rd_start} : region_end;
  assign diff    = $signed({3'b000, cmp_lhs} - {2'b00, pnew});
  assign fits    = diff >= $signed({3'b000, rsize});
  assign live    = seg_count - evc;
  assign p_comb  = (succ == NIL) ? addr_last : rd_prev;
  assign seg_end = {2'b00, rd_start} + {1'b0, rd_bytes};

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  ffla_ram #(.WIDTH(24), .DEPTH(NUM_SLOTS)) u_start (
    .clk, .we(start_we), .waddr(s), .wdata(pnew[23:0]), .raddr, .rdata(rd_start));
  ffla_ram #(.WIDTH(25), .DEPTH(NUM_SLOTS)) u_bytes (
    .clk, .we(bytes_we), .waddr(s), .wdata(rsize), .raddr, .rdata(rd_bytes));
  ffla_ram #(.WIDTH(USER_BITS), .DEPTH(NUM_SLOTS)) u_owner (
    .clk, .we(owner_we), .waddr(s), .wdata(usr), .raddr, .rdata(rd_owner));
  ffla_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_SLOTS)) u_next (
    .clk, .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr, .rdata(rd_next));
  ffla_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_SLOTS)) u_prev (
    .clk, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr, .rdata(rd_prev));
  ffla_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_SLOTS)) u_newer (
    .clk, .we(newer_we), .waddr(newer_wa), .wdata(newer_wd), .raddr, .rdata(rd_newer));
  ffla_ram #(.WIDTH(LINK_BITS), .DEPTH(NUM_SLOTS)) u_older (
    .clk, .we(older_we), .waddr(older_wa), .wdata(older_wd), .raddr, .rdata(rd_older));
  ffla_ram #(.WIDTH(SLOT_BITS), .DEPTH(NUM_USERS)) u_uslot (
    .clk, .we(uslot_we), .waddr(usr), .wdata(s), .raddr(cmd.user_id), .rdata(rd_uslot));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (start) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (act)
          ACT_ALLOC: state_next = (user_has[usr] || rsize == 25'd0 || cmd_zero) ? S_DONE
                                                                                : S_ALOOP;
          ACT_FREE:  state_next = user_has[usr] ? S_RELRD : S_DONE;
          ACT_CHECK: state_next = user_has[usr] ? S_TRD : S_DONE;
          default:   state_next = S_FLOOP;
        endcase
      end
      S_ALOOP: begin
        priority if (live == 7'd0) state_next = fits ? S_CSCAN : S_DONE;
        else if (seg_count == 7'(NUM_SLOTS) && evc == 7'd0) state_next = S_EVICT;
        else state_next = S_WRD;
      end
      S_WRD: begin
        if (cur == NIL) state_next = fits ? S_CSCAN : S_EVICT;
        else state_next = S_WCHK;
      end
      S_WCHK: begin
        priority if (gone[cur[SLOT_BITS-1:0]]) state_next = S_WRD;
        else if (fits) state_next = S_CSCAN;
        else state_next = S_WRD;
      end
      S_EVICT:  state_next = S_EVWAIT;
      S_EVWAIT: state_next = S_ALOOP;
      S_CSCAN: begin
        priority if (ci == 7'(NUM_SLOTS)) state_next = S_FIND;
        else if (gone[ci[SLOT_BITS-1:0]]) state_next = S_RELRD;
        else state_next = S_CSCAN;
      end
      S_RELRD: state_next = S_RELWR;
      S_RELWR: begin
        unique case (act)
          ACT_FREE:  state_next = S_DONE;
          ACT_FLUSH: state_next = S_FLOOP;
          default:   state_next = S_CSCAN;
        endcase
      end
      S_FIND:   if (!in_use[ci[SLOT_BITS-1:0]]) state_next = S_PRD;
      S_PRD:    state_next = S_PW1;
      S_PW1:    state_next = S_PW2;
      S_PW2:    state_next = S_DONE;
      S_FLOOP:  state_next = (addr_first == NIL) ? S_DONE : S_RELRD;
      S_TRD:    state_next = S_TUL;
      S_TUL:    state_next = S_TMR;
      S_TMR:    state_next = S_TNN;
      S_TNN:    state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    raddr    = s;
    start_we = 1'b0;
    bytes_we = 1'b0;
    owner_we = 1'b0;
    uslot_we = 1'b0;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    newer_we = 1'b0;
    older_we = 1'b0;
    next_wa  = s;
    prev_wa  = s;
    newer_wa = s;
    older_wa = s;
    next_wd  = NIL;
    prev_wd  = NIL;
    newer_wd = NIL;
    older_wd = NIL;
    unique case (state)
      S_WRD:   raddr = cur[SLOT_BITS-1:0];
      S_EVICT: raddr = ev_ptr[SLOT_BITS-1:0];
      S_PRD:   raddr = succ[SLOT_BITS-1:0];
      S_RELWR, S_TUL: begin
        if (state == S_RELWR) begin
          next_we = (rd_prev != NIL);
          next_wa = rd_prev[SLOT_BITS-1:0];
          next_wd = rd_next;
          prev_we = (rd_next != NIL);
          prev_wa = rd_next[SLOT_BITS-1:0];
          prev_wd = rd_prev;
        end
        newer_we = (rd_older != NIL);
        newer_wa = rd_older[SLOT_BITS-1:0];
        newer_wd = rd_newer;
        older_we = (rd_newer != NIL);
        older_wa = rd_newer[SLOT_BITS-1:0];
        older_wd = rd_older;
      end
      S_PW1: begin
        start_we = 1'b1;
        bytes_we = 1'b1;
        owner_we = 1'b1;
        uslot_we = 1'b1;
        next_we  = 1'b1;
        next_wd  = succ;
        prev_we  = 1'b1;
        prev_wd  = p_comb;
        newer_we = (newest != NIL);
        newer_wa = newest[SLOT_BITS-1:0];
        newer_wd = {1'b0, s};
        older_we = 1'b1;
        older_wd = newest;
      end
      S_PW2: begin
        next_we  = (p_link != NIL);
        next_wa  = p_link[SLOT_BITS-1:0];
        next_wd  = {1'b0, s};
        prev_we  = (succ != NIL);
        prev_wa  = succ[SLOT_BITS-1:0];
        prev_wd  = {1'b0, s};
        newer_we = 1'b1;
      end
      S_TMR: begin
        newer_we = (newest != NIL);
        newer_wa = newest[SLOT_BITS-1:0];
        newer_wd = {1'b0, s};
        older_we = 1'b1;
        older_wd = newest;
      end
      S_TNN:   newer_we = 1'b1;
      default: raddr = s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_use       <= '0;
      user_has     <= '0;
      gone         <= '0;
      seg_count    <= '0;
      addr_first   <= NIL;
      addr_last    <= NIL;
      newest       <= NIL;
      oldest       <= NIL;
      region_start <= '0;
      region_end   <= 25'h1000000;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REGION_START: region_start <= cfg_data[23:0];
          default:          region_end   <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: if (start) begin
          act      <= cmd.action;
          usr      <= cmd.user_id;
          cmd_zero <= (cmd.request_size == 24'd0);
          rsize    <= ({1'b0, cmd.request_size} + 25'(HEADER_BYTES + 15)) & ~25'd15;
        end
        S_DISPATCH: begin
          s      <= rd_uslot;
          gone   <= '0;
          evc    <= '0;
          ev_ptr <= oldest;
          pnew   <= {2'b00, region_start};
          result.data_offset   <= '0;
          result.evicted_count <= '0;
          unique case (act)
            ACT_ALLOC: begin
              if (user_has[usr]) result.status <= ST_ALREADY;
              else if (cmd_zero) result.status <= ST_BAD_SIZE;
              else result.status <= ST_OK;
            end
            ACT_FREE:  result.status <= user_has[usr] ? ST_OK : ST_NOT_ALLOC;
            ACT_CHECK: result.status <= user_has[usr] ? ST_OK : ST_MISS;
            default:   result.status <= ST_OK;
          endcase
        end
        S_ALOOP: begin
          priority if (live == 7'd0) begin
            succ <= NIL;
            ci   <= '0;
            if (!fits) result.status <= ST_TOO_LARGE;
          end else begin
            cur <= addr_first;
          end
        end
        S_WRD: if (cur == NIL && fits) begin
          succ <= NIL;
          ci   <= '0;
        end
        S_WCHK: begin
          priority if (gone[cur[SLOT_BITS-1:0]]) begin
            cur <= rd_next;
          end else if (fits) begin
            succ <= cur;
            ci   <= '0;
          end else begin
            pnew <= seg_end;
            cur  <= rd_next;
          end
        end
        S_EVICT: begin
          gone[ev_ptr[SLOT_BITS-1:0]] <= 1'b1;
          evc <= evc + 7'd1;
        end
        S_EVWAIT: begin
          ev_ptr <= rd_newer;
          pnew   <= {2'b00, region_start};
        end
        S_CSCAN: begin
          priority if (ci == 7'(NUM_SLOTS)) ci <= '0;
          else if (gone[ci[SLOT_BITS-1:0]]) s <= ci[SLOT_BITS-1:0];
          else ci <= ci + 7'd1;
        end
        S_RELWR: begin
          if (rd_prev == NIL) addr_first <= rd_next;
          if (rd_next == NIL) addr_last <= rd_prev;
          if (rd_older == NIL) oldest <= rd_newer;
          if (rd_newer == NIL) newest <= rd_older;
          in_use[s]          <= 1'b0;
          user_has[rd_owner] <= 1'b0;
          seg_count          <= seg_count - 7'd1;
          if (act == ACT_ALLOC) ci <= ci + 7'd1;
        end
        S_FIND: begin
          if (!in_use[ci[SLOT_BITS-1:0]]) s <= ci[SLOT_BITS-1:0];
          else ci <= ci + 7'd1;
        end
        S_PW1: begin
          p_link <= p_comb;
          newest <= {1'b0, s};
          if (newest == NIL) oldest <= {1'b0, s};
          in_use[s]     <= 1'b1;
          user_has[usr] <= 1'b1;
          seg_count     <= seg_count + 7'd1;
        end
        S_PW2: begin
          if (p_link == NIL) addr_first <= {1'b0, s};
          if (succ == NIL) addr_last <= {1'b0, s};
          result.status        <= ST_OK;
          result.data_offset   <= pnew[23:0] + 24'(HEADER_BYTES);
          result.evicted_count <= evc;
        end
        S_FLOOP: s <= addr_first[SLOT_BITS-1:0];
        S_TUL: begin
          if (rd_older == NIL) oldest <= rd_newer;
          if (rd_newer == NIL) newest <= rd_older;
          pnew <= {2'b00, rd_start};
        end
        S_TMR: begin
          if (newest == NIL) oldest <= {1'b0, s};
          newest <= {1'b0, s};
        end
        S_TNN: result.data_offset <= pnew[23:0] + 24'(HEADER_BYTES);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (32'(seg_count) == 32'($countones(in_use))))
    else $error("segment count out of step with slot use");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ((seg_count == 7'd0) == (addr_first == NIL)))
    else $error("address list and segment count disagree");
  a_lru: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ((newest == NIL) == (oldest == NIL)))
    else $error("recency list ends disagree");
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("item result not followed by idle");
`endif

endmodule
